// ----- rtl/spr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse rate calculator package
// Shared constants, register indexes and the microcode program of the
// sequencer that controls the divider datapath.
// ----------------------------------------------------------------------------
package spr_pkg;

    // Default values of the top-level parameters.
    localparam int MAX_CHANNELS_DEF  = 8;
    localparam int FRACTION_BITS_DEF = 15;

    // Field widths fixed by the interface.
    localparam int STEP_W    = 17;
    localparam int COUNT_W   = 16;
    localparam int PERIOD_W  = 16;
    localparam int FRAC_W    = 15;
    localparam int CHAN_W    = 3;
    localparam int DIR_W     = 8;
    localparam int TICKS_W   = 24;
    localparam int FRAME_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 24;

    // Limits of the result fields.
    localparam logic [COUNT_W-1:0]  COUNT_LIMIT  = 16'hFFFF;
    localparam logic [PERIOD_W-1:0] PERIOD_LIMIT = 16'hFFFF;
    localparam logic [FRAC_W-1:0]   FRAC_LIMIT   = 15'h7FFF;

    // Reset values of the configuration registers.
    localparam logic [TICKS_W-1:0] PERIOD_TICKS_RST   = 24'd33750;
    localparam logic [FRAME_W-1:0] FRAME_CHANNELS_RST = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_CHANNELS = 1'b1;

    // Microcode program counter width.
    localparam int PC_W = 2;

    // Datapath operations.
    localparam logic [1:0] OP_NOP    = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_DIV    = 2'd2;
    localparam logic [1:0] OP_RESULT = 2'd3;

    // Jump conditions.
    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_NO_INPUT = 3'd1;
    localparam logic [2:0] COND_ZERO     = 3'd2;
    localparam logic [2:0] COND_LOOP     = 3'd3;
    localparam logic [2:0] COND_OUT_BUSY = 3'd4;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_WAIT   = 2'd0;
    localparam logic [PC_W-1:0] PC_CHECK  = 2'd1;
    localparam logic [PC_W-1:0] PC_DIVIDE = 2'd2;
    localparam logic [PC_W-1:0] PC_FINISH = 2'd3;

    // One control word of the sequencer.
    typedef struct packed {
        logic [1:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ucode_word_t;

    // Microcode program. A taken jump goes to target, else the program
    // counter advances by one and wraps from the last word to the first.
    function automatic ucode_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_word_t w;
        unique case (pc)
            PC_WAIT:   w = '{op: OP_LOAD,   cond: COND_NO_INPUT, target: PC_WAIT};
            PC_CHECK:  w = '{op: OP_NOP,    cond: COND_ZERO,     target: PC_FINISH};
            PC_DIVIDE: w = '{op: OP_DIV,    cond: COND_LOOP,     target: PC_DIVIDE};
            PC_FINISH: w = '{op: OP_RESULT, cond: COND_OUT_BUSY, target: PC_FINISH};
            default:   w = '{op: OP_NOP,    cond: COND_NEVER,    target: PC_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/step_pulse_rate_calculator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse rate calculator
// Turns signed per-channel step counts into pulse periods with a fraction,
// using a restoring divider under control of a small microcode program.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the input channel (in_valid, in_stall, step_count) carries
// the signed step count of the next channel of a frame. Each input gives one
// transfer on the output channel (out_valid, out_stall and the result fields).
// The tick period divided by the count magnitude yields the pulse period and
// FRACTION_BITS fraction bits; direction bits of the frame appear on the
// result flagged frame_last.
// Timing: the divider retires one quotient bit per cycle, 24 + FRACTION_BITS
// bits in all. One item is in work at a time; the next input is taken in the
// cycle after the result is registered, even while that result is still held
// by a stalled receiver. A stalled receiver holds the output register steady;
// the sequencer then waits in its last step with the next result until the
// register frees up. Reset restores period_ticks to 33750 and frame_channels
// to 8 and starts at channel 0 with no direction bits. The config port
// (cfg_write, cfg_index, cfg_data) must be written only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module step_pulse_rate_calculator
    import spr_pkg::*;
#(
    parameter int MAX_CHANNELS  = MAX_CHANNELS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_write,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DAT_W-1:0]        cfg_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [STEP_W-1:0]    step_count,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [CHAN_W-1:0]           channel,
    output logic [COUNT_W-1:0]          pulse_count,
    output logic [PERIOD_W-1:0]         pulse_period,
    output logic [FRAC_W-1:0]           period_fraction,
    output logic                        period_saturated,
    output logic [DIR_W-1:0]            direction_bits,
    output logic                        frame_last
);

    // Dividend width, loop counter width and fraction compare width.
    localparam int DVD_W = TICKS_W + FRACTION_BITS;
    localparam int CNT_W = $clog2(DVD_W);
    localparam int FPW   = (FRACTION_BITS > FRAC_W) ? FRACTION_BITS : FRAC_W;
    localparam logic [CNT_W-1:0]   LAST_STEP = CNT_W'(DVD_W - 1);
    localparam logic [FRAME_W-1:0] MAX_LEN   = FRAME_W'(MAX_CHANNELS);

    // Configuration registers.
    logic [TICKS_W-1:0] period_ticks_reg;
    logic [FRAME_W-1:0] frame_channels_reg;

    // Sequencer and datapath registers.
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] mag_reg;
    logic               neg_reg;
    logic [CHAN_W-1:0]  chan_reg;
    logic [DIR_W-1:0]   dir_acc_reg;

    // Output register.
    logic                out_valid_reg;
    logic [CHAN_W-1:0]   channel_reg;
    logic [COUNT_W-1:0]  pulse_count_reg;
    logic [PERIOD_W-1:0] pulse_period_reg;
    logic [FRAC_W-1:0]   period_fraction_reg;
    logic                period_saturated_reg;
    logic [DIR_W-1:0]    direction_bits_reg;
    logic                frame_last_reg;

    ucode_word_t        uword;
    logic               cond_true;
    logic               in_take;
    logic               out_busy;
    logic               result_en;
    logic [STEP_W-1:0]  raw_mag;
    logic [COUNT_W-1:0] in_mag;
    logic [COUNT_W:0]   trial;
    logic [COUNT_W:0]   diff;
    logic               quot_bit;
    logic               sat;
    logic [FPW-1:0]     frac_ext;
    logic [FRAC_W-1:0]  frac_val;
    logic [FRAME_W-1:0] len_eff;
    logic               last;
    logic [DIR_W-1:0]   dir_next;

    // Fetch the control word and evaluate its jump condition.
    assign uword    = ucode_rom(pc_reg);
    assign in_stall = (uword.op != OP_LOAD);
    assign in_take  = in_valid && !in_stall;
    assign out_busy = out_valid_reg && out_stall;

    always_comb
    begin
        case (uword.cond)
            COND_NO_INPUT: cond_true = !in_valid;
            COND_ZERO:     cond_true = (mag_reg == '0);
            COND_LOOP:     cond_true = (cnt_reg != LAST_STEP);
            COND_OUT_BUSY: cond_true = out_busy;
            default:       cond_true = 1'b0;
        endcase
    end

    assign pc_next   = cond_true ? uword.target : pc_reg + 1'b1;
    assign result_en = (uword.op == OP_RESULT) && !out_busy;

    // Magnitude of the incoming count, clamped to 16 bits.
    assign raw_mag = step_count[STEP_W-1] ? (~step_count + 1'b1) : step_count;
    assign in_mag  = raw_mag[STEP_W-1] ? COUNT_LIMIT : raw_mag[COUNT_W-1:0];

    // One restoring divide step.
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff     = trial - {1'b0, mag_reg};
    assign quot_bit = !diff[COUNT_W];

    // Result formatting from the finished quotient.
    assign sat      = |dvd_reg[DVD_W-1:FRACTION_BITS+PERIOD_W];
    assign frac_ext = FPW'(dvd_reg[FRACTION_BITS-1:0]);
    assign frac_val = (frac_ext > FPW'(FRAC_LIMIT)) ? FRAC_LIMIT : frac_ext[FRAC_W-1:0];

    // Frame length clamp and end-of-frame detection.
    always_comb
    begin
        if (frame_channels_reg == '0)
        begin
            len_eff = FRAME_W'(1);
        end
        else if (frame_channels_reg > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = frame_channels_reg;
        end
    end

    assign last     = (FRAME_W'(chan_reg) >= (len_eff - 1'b1));
    assign dir_next = dir_acc_reg | (DIR_W'(neg_reg) << chan_reg);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_ticks_reg   <= PERIOD_TICKS_RST;
            frame_channels_reg <= FRAME_CHANNELS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PERIOD_TICKS:   period_ticks_reg   <= cfg_data[TICKS_W-1:0];
                REG_FRAME_CHANNELS: frame_channels_reg <= cfg_data[FRAME_W-1:0];
                default:            ;
            endcase
        end
    end

    // Sequencer control state: program counter, frame position, direction bits, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_WAIT;
            chan_reg      <= '0;
            dir_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (result_en)
            begin
                out_valid_reg <= 1'b1;
                if (last)
                begin
                    chan_reg    <= '0;
                    dir_acc_reg <= '0;
                end
                else
                begin
                    chan_reg    <= chan_reg + 1'b1;
                    dir_acc_reg <= dir_next;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Divider datapath.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dvd_reg <= {period_ticks_reg, {FRACTION_BITS{1'b0}}};
            rem_reg <= '0;
            cnt_reg <= '0;
            mag_reg <= in_mag;
            neg_reg <= step_count[STEP_W-1];
        end
        else if (uword.op == OP_DIV)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], quot_bit};
            rem_reg <= quot_bit ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Output register load.
    always_ff @(posedge clk)
    begin
        if (result_en)
        begin
            channel_reg     <= chan_reg;
            pulse_count_reg <= mag_reg;
            frame_last_reg  <= last;
            direction_bits_reg <= last ? dir_next : '0;
            if (mag_reg == '0)
            begin
                pulse_period_reg     <= '0;
                period_fraction_reg  <= '0;
                period_saturated_reg <= 1'b0;
            end
            else if (sat)
            begin
                pulse_period_reg     <= PERIOD_LIMIT;
                period_fraction_reg  <= FRAC_LIMIT;
                period_saturated_reg <= 1'b1;
            end
            else
            begin
                pulse_period_reg     <= dvd_reg[FRACTION_BITS+PERIOD_W-1:FRACTION_BITS];
                period_fraction_reg  <= frac_val;
                period_saturated_reg <= 1'b0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign channel          = channel_reg;
    assign pulse_count      = pulse_count_reg;
    assign pulse_period     = pulse_period_reg;
    assign period_fraction  = period_fraction_reg;
    assign period_saturated = period_saturated_reg;
    assign direction_bits   = direction_bits_reg;
    assign frame_last       = frame_last_reg;

endmodule

// ----- tb/step_pulse_rate_calculator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step pulse rate calculator testbench
// Drives signed step counts through the valid/stall input channel across a
// series of tick-period and frame-length settings, with random idling on both
// sides. A scoreboard predicts every result and checks each output transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module step_pulse_rate_calculator_test
    import spr_pkg::*;
;

    localparam int MAX_CHANNELS  = MAX_CHANNELS_DEF;
    localparam int FRACTION_BITS = FRACTION_BITS_DEF;
    localparam int QUIET_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int PHASE_COUNT   = 9;
    localparam int PHASE_ITEMS   = 82;

    typedef logic signed [STEP_W-1:0] step_t;

    // One result of the block.
    typedef struct {
        logic [CHAN_W-1:0]   channel;
        logic [COUNT_W-1:0]  count;
        logic [PERIOD_W-1:0] period;
        logic [FRAC_W-1:0]   fraction;
        logic                saturated;
        logic [DIR_W-1:0]    directions;
        logic                is_last;
    } rate_result_t;

    // Predicts pulse settings from accepted step counts and checks results.
    class pulse_rate_book;
        logic [TICKS_W-1:0] period_ticks;
        logic [FRAME_W-1:0] frame_channels;
        logic [CHAN_W-1:0]  next_channel;
        logic [DIR_W-1:0]   negative_mask;
        rate_result_t       pending_rates[$];
        int                 mismatch_count;
        int                 result_count;
        int                 frame_count;
        int                 saturated_count;

        function new();
            period_ticks    = PERIOD_TICKS_RST;
            frame_channels  = FRAME_CHANNELS_RST;
            next_channel    = '0;
            negative_mask   = '0;
            mismatch_count  = 0;
            result_count    = 0;
            frame_count     = 0;
            saturated_count = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            if (idx == REG_PERIOD_TICKS)
                period_ticks = data[TICKS_W-1:0];
            else if (idx == REG_FRAME_CHANNELS)
                frame_channels = data[FRAME_W-1:0];
        endfunction

        // Works out the result of one accepted step count and queues it.
        function void note_step(step_t step);
            logic [STEP_W-1:0]  raw;
            logic [STEP_W-1:0]  mag_full;
            logic [COUNT_W-1:0] mag;
            logic [63:0]        quotient;
            logic [63:0]        whole;
            logic [63:0]        part;
            int unsigned        len;
            rate_result_t       r;

            raw      = step;
            mag_full = raw[STEP_W-1] ? (~raw + 1'b1) : raw;
            mag      = (mag_full > COUNT_LIMIT) ? COUNT_LIMIT : mag_full[COUNT_W-1:0];

            r.channel   = next_channel;
            r.count     = mag;
            r.period    = '0;
            r.fraction  = '0;
            r.saturated = 1'b0;

            // Fixed-point division of the tick period by the magnitude.
            if (mag != '0)
            begin
                quotient = (64'(period_ticks) << FRACTION_BITS) / 64'(mag);
                whole    = quotient >> FRACTION_BITS;
                part     = quotient & ((64'd1 << FRACTION_BITS) - 64'd1);
                if (whole > 64'(PERIOD_LIMIT))
                begin
                    r.period    = PERIOD_LIMIT;
                    r.fraction  = FRAC_LIMIT;
                    r.saturated = 1'b1;
                end
                else
                begin
                    r.period   = whole[PERIOD_W-1:0];
                    r.fraction = (part > 64'(FRAC_LIMIT)) ? FRAC_LIMIT : part[FRAC_W-1:0];
                end
            end

            // Frame length is clamped into the supported range.
            len = frame_channels;
            if (len < 1)
                len = 1;
            if (len > MAX_CHANNELS)
                len = MAX_CHANNELS;

            if (raw[STEP_W-1])
                negative_mask[next_channel] = 1'b1;

            r.is_last    = (next_channel >= len - 1);
            r.directions = r.is_last ? negative_mask : '0;

            if (r.is_last)
            begin
                next_channel  = '0;
                negative_mask = '0;
            end
            else
            begin
                next_channel = next_channel + 1'b1;
            end
            pending_rates.push_back(r);
        endfunction

        function void compare_field(string field, longint unsigned want, longint unsigned got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatch_count++;
            end
        endfunction

        // Checks one output transfer against the oldest prediction.
        function void check_result(rate_result_t seen);
            rate_result_t want;

            if (pending_rates.size() == 0)
            begin
                $error("result on channel %0d arrived with nothing expected", seen.channel);
                mismatch_count++;
                return;
            end
            want = pending_rates.pop_front();
            compare_field("channel", want.channel, seen.channel);
            compare_field("pulse_count", want.count, seen.count);
            compare_field("pulse_period", want.period, seen.period);
            compare_field("period_fraction", want.fraction, seen.fraction);
            compare_field("period_saturated", want.saturated, seen.saturated);
            compare_field("direction_bits", want.directions, seen.directions);
            compare_field("frame_last", want.is_last, seen.is_last);
            result_count++;
            if (seen.is_last)
                frame_count++;
            if (seen.saturated)
                saturated_count++;
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    step_t                step_count;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CHAN_W-1:0]    channel;
    logic [COUNT_W-1:0]   pulse_count;
    logic [PERIOD_W-1:0]  pulse_period;
    logic [FRAC_W-1:0]    period_fraction;
    logic                 period_saturated;
    logic [DIR_W-1:0]     direction_bits;
    logic                 frame_last;

    pulse_rate_book book;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles = 0;
    int setting_count = 0;

    step_pulse_rate_calculator i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .step_count       (step_count),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .channel          (channel),
        .pulse_count      (pulse_count),
        .pulse_period     (pulse_period),
        .period_fraction  (period_fraction),
        .period_saturated (period_saturated),
        .direction_bits   (direction_bits),
        .frame_last       (frame_last)
    );

    always #1 clk = ~clk;

    // The receiver stalls at random with the current probability.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Every output transfer goes to the scoreboard.
    always @(posedge clk)
    begin : watch_results
        rate_result_t seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.channel    = channel;
            seen.count      = pulse_count;
            seen.period     = pulse_period;
            seen.fraction   = period_fraction;
            seen.saturated  = period_saturated;
            seen.directions = direction_bits;
            seen.is_last    = frame_last;
            book.check_result(seen);
        end
    end

    // Watchdog: the run ends if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout after %0d cycles with no transfer", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sends one step count and notes it once the transfer happens.
    task automatic send_step(input step_t value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        step_count <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_step(value);
    endtask

    task automatic send_list(input int values[$]);
        foreach (values[i])
            send_step(step_t'(values[i]));
    endtask

    // Waits for the block to go idle, then writes both registers.
    task automatic apply_setting(input logic [TICKS_W-1:0] ticks,
                                 input logic [FRAME_W-1:0] frame);
        in_valid <= 1'b0;
        while (book.pending_rates.size() != 0)
            @(negedge clk);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_PERIOD_TICKS;
        cfg_data  <= CFG_DAT_W'(ticks);
        book.set_register(REG_PERIOD_TICKS, CFG_DAT_W'(ticks));
        @(posedge clk);
        cfg_index <= REG_FRAME_CHANNELS;
        cfg_data  <= CFG_DAT_W'(frame);
        book.set_register(REG_FRAME_CHANNELS, CFG_DAT_W'(frame));
        @(posedge clk);
        cfg_write <= 1'b0;
        setting_count++;
    endtask

    // Mix of full-range, small, medium and corner step counts.
    function automatic step_t random_step();
        int corner_values[8];
        int magnitude;

        corner_values = '{0, 1, -1, 2, -2, 65535, -65535, -65536};
        case ($urandom_range(0, 9)) inside
            [0:3]: return step_t'($urandom_range(0, 131071));
            [4:5]: return step_t'(int'($urandom_range(0, 600)) - 300);
            6:     return step_t'(corner_values[$urandom_range(0, 7)]);
            [7:8]:
            begin
                magnitude = $urandom_range(1, 4095);
                return step_t'($urandom_range(0, 1) ? -magnitude : magnitude);
            end
            default: return '0;
        endcase
    endfunction

    initial
    begin
        logic [TICKS_W-1:0] ticks;
        logic [FRAME_W-1:0] frame;

        book           = new();
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        step_count     = '0;
        send_idle_pct  = 8;
        recv_stall_pct = 64;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: one full frame with count extremes and both signs.
        send_list('{0, 1, -1, 65535, -65535, -65536, 32768, -135});

        // Long tick period: small counts overflow the period and saturate.
        apply_setting(24'd8847360, 4'd3);
        send_list('{1, -2, 135, -65536, 0, 65535});

        // Zero tick period, and a frame length of zero acting as one.
        apply_setting(24'd0, 4'd0);
        send_list('{7, -7, 0});

        // Frame length above the maximum; leave the frame open at channel 2.
        apply_setting(24'hFFFFFF, 4'd15);
        send_list('{1, -300});

        // Shorten the frame mid-way: the next item must end it.
        apply_setting(24'd300, 4'd2);
        send_list('{-9, 256, 0});

        // Random phases over a range of settings and idling patterns.
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p / 3)
                0:
                begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 64;
                end
                1:
                begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 8;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case (p)
                0:
                begin
                    ticks = 24'd270;
                    frame = 4'd1;
                end
                1:
                begin
                    ticks = 24'd8847360;
                    frame = 4'd8;
                end
                2:
                begin
                    ticks = TICKS_W'($urandom());
                    frame = FRAME_W'($urandom_range(0, 15));
                end
                3:
                begin
                    ticks = 24'hFFFFFF;
                    frame = 4'd0;
                end
                4:
                begin
                    ticks = TICKS_W'(135 * $urandom_range(2, 65536));
                    frame = 4'd15;
                end
                5:
                begin
                    ticks = TICKS_W'($urandom_range(270, 8847360));
                    frame = FRAME_W'($urandom_range(1, 8));
                end
                6:
                begin
                    ticks = 24'd1;
                    frame = 4'd2;
                end
                7:
                begin
                    ticks = 24'd0;
                    frame = FRAME_W'($urandom_range(1, 8));
                end
                default:
                begin
                    ticks = PERIOD_TICKS_RST;
                    frame = 4'd5;
                end
            endcase
            apply_setting(ticks, frame);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_step(random_step());
        end

        // Let every result come out, then give the block time to misbehave.
        in_valid <= 1'b0;
        while (book.pending_rates.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results in %0d frames (%0d saturated) over %0d register settings.",
                 book.result_count, book.frame_count, book.saturated_count, setting_count);
        $display("Idling covered sender gaps, receiver stalls, both reversed, and none.");
        if (book.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- step_pulse_rate_calculator.f -----
rtl/spr_pkg.sv
rtl/step_pulse_rate_calculator.sv
tb/step_pulse_rate_calculator_test.sv
